// ===== src/q2e_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package q2e_pkg;

   // Stream payload widths.
   localparam int QUAT_W   = 16;
   localparam int REQ_W    = 64;
   localparam int RSP_W    = 48;
   localparam int ROLL_W   = 16;
   localparam int PITCH_W  = 15;
   localparam int YAW_W    = 16;

   // Internal arithmetic widths.
   localparam int PROD_W   = 32;   // one 16 x 16 product
   localparam int OPW      = 34;   // atan2 operands in units of 2^-28
   localparam int SW       = 30;   // saturated sine, [-2^28, 2^28]
   localparam int MAGW     = 29;   // magnitude of the sine
   localparam int RADW     = 57;   // radicand 2^56 - s^2
   localparam int ROOTW    = 29;   // square root result, one stage per bit
   localparam int ISQW     = 58;   // remainder and root width inside the square root
   localparam int CW       = 36;   // CORDIC vector width
   localparam int ANGW     = 25;   // angle accumulator in units of 2^-16 degree
   localparam int AOUTW    = 16;   // rounded angle in units of 1/128 degree
   localparam int TABW     = 22;
   localparam int ATAN_LEN = 24;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int FIFO_DEPTH       = 4;

   localparam logic signed [ANGW-1:0] DEG90 = ANGW'(5898240);

   // atan(2^-i) in units of 2^-16 degree.
   localparam logic [TABW-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
      22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
      22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
   };

   // Operands that travel alongside the square root.
   typedef struct packed {
      logic signed [OPW-1:0] roll_y;
      logic signed [OPW-1:0] roll_x;
      logic signed [OPW-1:0] yaw_y;
      logic signed [OPW-1:0] yaw_x;
      logic signed [SW-1:0]  s;
   } q2e_side_type;

   // One prepared item as it sits in the queue.
   typedef struct packed {
      q2e_side_type     side;
      logic [RADW-1:0]  rad;
      logic             clamped;
   } q2e_work_type;

   // Control tag that follows an item through the back end.
   typedef struct packed {
      logic valid;
      logic clamped;
   } q2e_tag_type;

endpackage

`default_nettype wire

// ===== src/quaternion_to_euler_angles.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A request passes through the four front stages, one queue slot, the
// 29-stage square root and the CORDIC pipeline with its output register.
// Throughput: one transaction per cycle while the queue is not full; the
// queue holds four prepared items.
// Reset clears all valid bits and queue pointers; data registers are not reset.
module quaternion_to_euler_angles #(
   parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // quat_w, quat_x, quat_y, quat_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // roll_deg, pitch_deg, yaw_deg, zero pad
   output logic [0:0]  rsp_tuser    // pitch_clamped
);
   import q2e_pkg::*;

   localparam int STEPS    = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
   localparam int BACK_LAT = ROOTW + STEPS + 1;

   localparam logic signed [AOUTW-1:0] FULL_LIM = AOUTW'(23040);
   localparam logic signed [AOUTW-1:0] HALF_LIM = AOUTW'(11520);

   function automatic logic signed [AOUTW-1:0] clamp_angle(
      input logic signed [AOUTW-1:0] a,
      input logic signed [AOUTW-1:0] lim
   );
      logic signed [AOUTW-1:0] r;
      r = a;
      if (a > lim) begin
         r = lim;
      end else if (a < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

   logic          front_en, front_valid, q_full, q_nempty, back_en;
   q2e_work_type  front_work, head_work;
   logic [ROOTW-1:0] root;
   q2e_side_type  side_res;
   q2e_tag_type   tag_ff [0:BACK_LAT-1];
   logic signed [AOUTW-1:0] roll_ang, pitch_ang, yaw_ang, pitch_lim;
   logic                    rsp_valid_ff, clamped_ff;
   logic signed [ROLL_W-1:0]  roll_ff;
   logic signed [PITCH_W-1:0] pitch_ff;
   logic signed [YAW_W-1:0]   yaw_ff;

   // Front end moves whenever the queue has room.
   assign front_en   = !q_full;
   assign req_tready = front_en;

   q2e_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (front_en),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .out_valid (front_valid),
      .out_work  (front_work)
   );

   q2e_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid && front_en),
      .push_work (front_work),
      .full      (q_full),
      .pop       (back_en && q_nempty),
      .not_empty (q_nempty),
      .head_work (head_work)
   );

   // Back end moves whenever the output register is free or being emptied.
   assign back_en = !rsp_valid_ff || rsp_tready;

   q2e_isqrt u_isqrt (
      .clock    (clock),
      .en       (back_en),
      .rad      (head_work.rad),
      .side_op  (head_work.side),
      .root     (root),
      .side_res (side_res)
   );

   q2e_cordic #(.STEPS(STEPS)) u_roll (
      .clock (clock),
      .en    (back_en),
      .x_op  (CW'(side_res.roll_x)),
      .y_op  (CW'(side_res.roll_y)),
      .angle (roll_ang)
   );

   q2e_cordic #(.STEPS(STEPS)) u_yaw (
      .clock (clock),
      .en    (back_en),
      .x_op  (CW'(side_res.yaw_x)),
      .y_op  (CW'(side_res.yaw_y)),
      .angle (yaw_ang)
   );

   q2e_cordic #(.STEPS(STEPS)) u_pitch (
      .clock (clock),
      .en    (back_en),
      .x_op  ($signed(CW'(root))),
      .y_op  (CW'(side_res.s)),
      .angle (pitch_ang)
   );

   // Valid and clamp flag follow the item through the back end.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < BACK_LAT; k++) begin
            tag_ff[k] <= '0;
         end
      end else if (back_en) begin
         tag_ff[0] <= '{valid: q_nempty, clamped: head_work.clamped};
         for (int k = 1; k < BACK_LAT; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   assign pitch_lim = clamp_angle(pitch_ang, HALF_LIM);

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (back_en) begin
         rsp_valid_ff <= tag_ff[BACK_LAT-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         clamped_ff <= tag_ff[BACK_LAT-1].clamped;
         roll_ff    <= clamp_angle(roll_ang, FULL_LIM);
         yaw_ff     <= clamp_angle(yaw_ang, FULL_LIM);
         pitch_ff   <= pitch_lim[PITCH_W-1:0];
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {1'b0, yaw_ff, pitch_ff, roll_ff};
   assign rsp_tuser[0] = clamped_ff;

endmodule

`default_nettype wire

// ===== src/q2e_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module q2e_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [63:0]           in_data,
   output logic                  out_valid,
   output q2e_pkg::q2e_work_type out_work
);
   import q2e_pkg::*;

   localparam logic signed [OPW-1:0] ONE_OP = OPW'(2**28);
   localparam logic signed [OPW-1:0] NEG_OP = -ONE_OP;
   localparam logic signed [SW-1:0]  S_POS  = SW'(2**28);
   localparam logic signed [SW-1:0]  S_NEG  = -S_POS;
   localparam logic [RADW-1:0]       RAD_TOP = RADW'(1) << (RADW - 1);

   logic signed [QUAT_W-1:0] qw, qx, qy, qz;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [PROD_W-1:0] p_wx_ff, p_yz_ff, p_xx_ff, p_yy_ff, p_wz_ff;
   logic signed [PROD_W-1:0] p_xy_ff, p_zz_ff, p_wy_ff, p_xz_ff;
   logic signed [OPW-1:0] s_raw;
   q2e_work_type w2_in, w2_ff, w3_ff, w4_ff, w4_in;
   logic [MAGW-1:0]       mag;
   logic signed [SW-1:0]  s_abs;
   logic [2*MAGW-1:0]     sq_in;
   logic [RADW-1:0]       sq_ff;

   assign qw = $signed(in_data[15:0]);
   assign qx = $signed(in_data[31:16]);
   assign qy = $signed(in_data[47:32]);
   assign qz = $signed(in_data[63:48]);

   // Valid bits of the four front stages; the whole front holds when en is low.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Stage 1: the nine component products.
   always_ff @(posedge clock) begin
      if (en) begin
         p_wx_ff <= qw * qx;
         p_yz_ff <= qy * qz;
         p_xx_ff <= qx * qx;
         p_yy_ff <= qy * qy;
         p_wz_ff <= qw * qz;
         p_xy_ff <= qx * qy;
         p_zz_ff <= qz * qz;
         p_wy_ff <= qw * qy;
         p_xz_ff <= qx * qz;
      end
   end

   // Stage 2: atan2 operands and the saturated sine of pitch.
   always_comb begin
      w2_in.side.roll_y = (OPW'(p_wx_ff) + OPW'(p_yz_ff)) <<< 1;
      w2_in.side.roll_x = ONE_OP - ((OPW'(p_xx_ff) + OPW'(p_yy_ff)) <<< 1);
      w2_in.side.yaw_y  = (OPW'(p_wz_ff) + OPW'(p_xy_ff)) <<< 1;
      w2_in.side.yaw_x  = ONE_OP - ((OPW'(p_yy_ff) + OPW'(p_zz_ff)) <<< 1);
      w2_in.rad         = '0;
      s_raw             = (OPW'(p_wy_ff) - OPW'(p_xz_ff)) <<< 1;
      if (s_raw > ONE_OP) begin
         w2_in.side.s  = S_POS;
         w2_in.clamped = 1'b1;
      end else if (s_raw < NEG_OP) begin
         w2_in.side.s  = S_NEG;
         w2_in.clamped = 1'b1;
      end else begin
         w2_in.side.s  = $signed(s_raw[SW-1:0]);
         w2_in.clamped = 1'b0;
      end
   end

   // Stage 3: square of the sine.
   assign s_abs = w2_ff.side.s[SW-1] ? -w2_ff.side.s : w2_ff.side.s;
   assign mag   = s_abs[MAGW-1:0];
   assign sq_in = mag * mag;

   // Stage 4: radicand for the cosine.
   always_comb begin
      w4_in     = w3_ff;
      w4_in.rad = RAD_TOP - sq_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w2_ff <= w2_in;
         w3_ff <= w2_ff;
         sq_ff <= sq_in[RADW-1:0];
         w4_ff <= w4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_work  = w4_ff;

endmodule

`default_nettype wire

// ===== src/q2e_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module q2e_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  q2e_pkg::q2e_work_type push_work,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output q2e_pkg::q2e_work_type head_work
);
   import q2e_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   q2e_work_type     mem_ff [0:FIFO_DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_work = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_work;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty)) else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH)) else $error("queue fill count out of range");

endmodule

`default_nettype wire

// ===== src/q2e_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module q2e_isqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [q2e_pkg::RADW-1:0]    rad,
   input  q2e_pkg::q2e_side_type       side_op,
   output logic [q2e_pkg::ROOTW-1:0]   root,
   output q2e_pkg::q2e_side_type       side_res
);
   import q2e_pkg::*;

   logic [ISQW-1:0] rem_ff  [0:ROOTW-1];
   logic [ISQW-1:0] res_ff  [0:ROOTW-1];
   q2e_side_type    side_ff [0:ROOTW-1];

   // One result bit per stage, from the top bit down.
   for (genvar j = 0; j < ROOTW; j++) begin : g_stage
      localparam logic [ISQW-1:0] BIT = ISQW'(1) << (2 * (ROOTW - 1 - j));
      logic [ISQW-1:0] rem_prev, res_prev, trial, rem_in, res_in;
      q2e_side_type    side_prev;

      if (j == 0) begin : g_first
         assign rem_prev  = ISQW'(rad);
         assign res_prev  = '0;
         assign side_prev = side_op;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign res_prev  = res_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      always_comb begin
         trial = res_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            res_ff[j]  <= res_in;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign root     = res_ff[ROOTW-1][ROOTW-1:0];
   assign side_res = side_ff[ROOTW-1];

endmodule

`default_nettype wire

// ===== src/q2e_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module q2e_cordic #(
   parameter int STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [q2e_pkg::CW-1:0]     x_op,
   input  logic signed [q2e_pkg::CW-1:0]     y_op,
   output logic signed [q2e_pkg::AOUTW-1:0]  angle
);
   import q2e_pkg::*;

   logic signed [CW-1:0]   x_ff [0:STEPS];
   logic signed [CW-1:0]   y_ff [0:STEPS];
   logic signed [ANGW-1:0] a_ff [0:STEPS];
   logic                   z_ff [0:STEPS];

   logic signed [CW-1:0]   x0_in, y0_in;
   logic signed [ANGW-1:0] a0_in, a_rnd;

   // Stage 0: fold the left half-plane over by a quarter turn.
   always_comb begin
      x0_in = x_op;
      y0_in = y_op;
      a0_in = '0;
      if (x_op < 0) begin
         if (y_op >= 0) begin
            a0_in = DEG90;
            x0_in = y_op;
            y0_in = -x_op;
         end else begin
            a0_in = -DEG90;
            x0_in = -y_op;
            y0_in = x_op;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= x0_in;
         y_ff[0] <= y0_in;
         a_ff[0] <= a0_in;
         z_ff[0] <= (x_op == 0) && (y_op == 0);
      end
   end

   // Vectoring iterations, one per stage.
   for (genvar i = 1; i <= STEPS; i++) begin : g_iter
      localparam logic signed [ANGW-1:0] STEP_ANG = $signed(ANGW'(ATAN_TAB[i-1]));
      logic signed [CW-1:0] dx, dy;

      assign dx = y_ff[i-1] >>> (i - 1);
      assign dy = x_ff[i-1] >>> (i - 1);

      always_ff @(posedge clock) begin
         if (en) begin
            z_ff[i] <= z_ff[i-1];
            if (y_ff[i-1] > 0) begin
               x_ff[i] <= x_ff[i-1] + dx;
               y_ff[i] <= y_ff[i-1] - dy;
               a_ff[i] <= a_ff[i-1] + STEP_ANG;
            end else begin
               x_ff[i] <= x_ff[i-1] - dx;
               y_ff[i] <= y_ff[i-1] + dy;
               a_ff[i] <= a_ff[i-1] - STEP_ANG;
            end
         end
      end
   end

   // Round to 1/128 degree; a zero vector gives a zero angle.
   assign a_rnd = a_ff[STEPS] + ANGW'(256);
   assign angle = z_ff[STEPS] ? '0 : $signed(a_rnd[ANGW-1:ANGW-AOUTW]);

endmodule

`default_nettype wire

// ===== sim/quaternion_to_euler_angles_test.sv =====
`timescale 1ns / 1ps

module quaternion_to_euler_angles_test;
   import q2e_pkg::*;

   localparam int N_STEPS = CORDIC_STEPS_DEF;
   localparam int N_RANDOM = 1330;

   typedef struct {
      logic signed [ROLL_W-1:0]  roll;
      logic signed [PITCH_W-1:0] pitch;
      logic signed [YAW_W-1:0]   yaw;
      logic                      clamped;
   } euler_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;   // quat_w, quat_x, quat_y, quat_z
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // roll_deg, pitch_deg, yaw_deg, zero pad
   logic [0:0] rsp_tuser;         // pitch_clamped

   int fail_count = 0;
   bit sending_done = 0;
   int hold_off = 0;

   quaternion_to_euler_angles u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("Mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // Arithmetic shift right, rounding toward minus infinity.
   function automatic longint shr(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint floor_sqrt(input longint unsigned v);
      longint unsigned root, bit_val;
      root = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val >>= 2;
      while (bit_val != 0) begin
         if (v >= root + bit_val) begin
            v -= root + bit_val;
            root = (root >> 1) + bit_val;
         end else begin
            root >>= 1;
         end
         bit_val >>= 2;
      end
      return longint'(root);
   endfunction

   // Vectoring CORDIC atan2, result in units of 1/128 degree before clamping.
   function automatic longint vector_angle(input longint y, input longint x);
      longint ang, t, dx, dy;
      int steps;
      ang = 0;
      steps = (N_STEPS > ATAN_LEN) ? ATAN_LEN : N_STEPS;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            ang = 90 <<< 16; t = x; x = y; y = -t;
         end else begin
            ang = -(90 <<< 16); t = x; x = -y; y = t;
         end
      end
      for (int i = 0; i < steps; i++) begin
         dx = shr(y, i);
         dy = shr(x, i);
         if (y > 0) begin
            x += dx; y -= dy; ang += longint'(ATAN_TAB[i]);
         end else begin
            x -= dx; y += dy; ang -= longint'(ATAN_TAB[i]);
         end
      end
      return shr(ang + 256, 9);
   endfunction

   function automatic longint limit(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic euler_type quat_to_euler(input logic [63:0] q);
      longint w, x, y, z, s, c, one;
      euler_type e;
      one = 64'sd1 <<< 28;
      w = longint'($signed(q[15:0]));
      x = longint'($signed(q[31:16]));
      y = longint'($signed(q[47:32]));
      z = longint'($signed(q[63:48]));
      e.roll = ROLL_W'(limit(vector_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y)), 23040));
      e.yaw = YAW_W'(limit(vector_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z)), 23040));
      s = 2 * (w * y - x * z);
      e.clamped = 1'b0;
      if (s > one) begin
         s = one; e.clamped = 1'b1;
      end else if (s < -one) begin
         s = -one; e.clamped = 1'b1;
      end
      c = floor_sqrt(longint'(one * one - s * s));
      e.pitch = PITCH_W'(limit(vector_angle(s, c), 11520));
      return e;
   endfunction

   // Scoreboard: expected angles in order of acceptance.
   class angle_scoreboard;
      euler_type pending[$];

      function void note_request(logic [63:0] q);
         pending.push_back(quat_to_euler(q));
      endfunction

      task check_response(logic [47:0] d, logic [0:0] u);
         euler_type e;
         if (pending.size() == 0) begin
            report_mismatch("unexpected transaction", d, 0);
            return;
         end
         e = pending.pop_front();
         if ($signed(d[15:0]) != e.roll) report_mismatch("roll", $signed(d[15:0]), e.roll);
         if ($signed(d[30:16]) != e.pitch)
            report_mismatch("pitch", $signed(d[30:16]), e.pitch);
         if ($signed(d[46:31]) != e.yaw) report_mismatch("yaw", $signed(d[46:31]), e.yaw);
         if (d[47] != 1'b0) report_mismatch("pad", d[47], 0);
         if (u[0] != e.clamped) report_mismatch("pitch_clamped", u[0], e.clamped);
      endtask
   endclass

   angle_scoreboard board = new();

   function automatic logic [63:0] pack_quat(input int w, x, y, z);
      return {16'(z), 16'(y), 16'(x), 16'(w)};
   endfunction

   // Random quaternion: mostly near unit length, some arbitrary noise.
   function automatic logic [63:0] random_quat();
      int w, x, y, z, sel;
      real a, b, c, d, n;
      sel = $urandom_range(0, 9);
      if (sel < 2) return {$urandom, $urandom};
      if (sel == 2) return pack_quat($urandom_range(0, 2) - 1, $urandom_range(0, 2) - 1,
                                     $urandom_range(0, 2) - 1, $urandom_range(0, 2) - 1);
      a = real'($urandom_range(0, 20000)) - 10000.0;
      b = real'($urandom_range(0, 20000)) - 10000.0;
      c = real'($urandom_range(0, 20000)) - 10000.0;
      d = real'($urandom_range(0, 20000)) - 10000.0;
      if (sel == 3) begin
         c = 0.0; b = 0.0;
      end
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) n = 1.0;
      w = int'(a / n * 16384.0) + $urandom_range(0, 6) - 3;
      x = int'(b / n * 16384.0) + $urandom_range(0, 6) - 3;
      y = int'(c / n * 16384.0) + $urandom_range(0, 6) - 3;
      z = int'(d / n * 16384.0) + $urandom_range(0, 6) - 3;
      return pack_quat(w, x, y, z);
   endfunction

   task automatic send_quat(input logic [63:0] q, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= q;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(q);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   // Stimulus.
   initial begin
      logic [63:0] directed[$];
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      directed = '{
         pack_quat(16384, 0, 0, 0), pack_quat(0, 0, 0, 0),
         pack_quat(0, 16384, 0, 0), pack_quat(0, -16384, 0, 0),
         pack_quat(0, 0, 16384, 0), pack_quat(0, 0, 0, 16384),
         pack_quat(11585, 0, 11585, 0), pack_quat(11585, 0, -11585, 0),
         pack_quat(32767, 0, 32767, 0), pack_quat(-32768, 0, 32767, 0),
         pack_quat(-32768, -32768, -32768, -32768), pack_quat(32767, 32767, 32767, 32767),
         pack_quat(0, 11585, 0, 11585), pack_quat(0, 11585, 0, -11585),
         pack_quat(8192, 8192, 8192, 8192), pack_quat(-8192, 8192, -8192, 8192),
         pack_quat(-1, 0, 0, 0), pack_quat(1, -1, 1, -1),
         {64{1'b1}}, 64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555
      };
      foreach (directed[i]) send_quat(directed[i], 1'b0);
      // Long receiver stall while requests keep coming.
      hold_off = 200;
      for (int i = 0; i < 80; i++) send_quat(random_quat(), 1'b1);
      wait_drained();
      for (int i = 0; i < N_RANDOM - 80; i++) begin
         send_quat(random_quat(), i % 300 > 200);
         if (i == 600) wait_drained();
      end
      req_tvalid <= 1'b0;
      sending_done = 1;
   end

   // Result side: random back-pressure, with an occasional long hold-off.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off) @(negedge clock);
            hold_off = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if ($urandom_range(0, 4) == 0) gap = 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_response(rsp_tdata, rsp_tuser);
         @(negedge clock);
      end
   end

   // End of run.
   initial begin
      wait (sending_done);
      while (board.pending.size() != 0) @(negedge clock);
      repeat (N_STEPS + 80) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
